@@ rtl/pft_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pft_pkg
// Shared types and constants for the Pareto front table.
// ----------------------------------------------------------------------------
package pft_pkg;

   localparam int CAPACITY = 64;
   localparam int MONITORS = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int FIELD_CNT_W = 7;

   typedef enum logic [1:0] {
      MODE_CLEAR = 2'd0,
      MODE_OFFER = 2'd1,
      MODE_READ  = 2'd2
   } mode_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] pair_id;
      logic [15:0] cost;
      logic [15:0] reach;
      logic [5:0]  monitor_a;
      logic [5:0]  monitor_b;
      logic [5:0]  read_index;
   } req_type;

   typedef struct packed {
      logic                   accepted;
      logic                   skipped;
      logic                   full_res;
      logic [FIELD_CNT_W-1:0] removed_count;
      logic [FIELD_CNT_W-1:0] entry_count;
      logic [15:0]            entry_id;
      logic [15:0]            entry_cost;
      logic [15:0]            entry_reach;
   } rsp_type;

   typedef struct packed {
      logic [15:0] id;
      logic [15:0] cost;
      logic [15:0] reach;
   } entry_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic clear;
      logic scan;
      logic append;
      logic read;
      logic respond;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [1:0] mode;
      logic       skip;
      logic       scan_done;
   } stat_type;

endpackage

@@ rtl/pft_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pft_ctrl
// Sequencer: dispatches each item by mode and steps the scan of the front.
// ----------------------------------------------------------------------------
module pft_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  pft_pkg::stat_type stat,
   output pft_pkg::cmd_type  cmd
);
   import pft_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE     = 5'b00001,
      S_DISPATCH = 5'b00010,
      S_SCAN     = 5'b00100,
      S_APPEND   = 5'b01000,
      S_RESP     = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = S_RESP;
            case (stat.mode)
               MODE_CLEAR: cmd.clear = 1'b1;
               MODE_OFFER: begin
                  if (!stat.skip) state_in = S_SCAN;
               end
               MODE_READ:  cmd.read = 1'b1;
               default:    ;
            endcase
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) state_in = S_APPEND;
         end
         S_APPEND: begin
            cmd.append = 1'b1;
            state_in   = S_RESP;
         end
         S_RESP: begin
            cmd.respond = 1'b1;
            state_in    = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   assign busy = (state_ff != S_IDLE);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after item accept");

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("controller state not one-hot");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (cmd.scan || cmd.append || cmd.respond) |-> busy)
      else $error("datapath command issued while idle");

endmodule

@@ rtl/pft_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pft_dp
// Datapath: front memory, scan/compaction pointers, result register.
// ----------------------------------------------------------------------------
module pft_dp (
   input  logic              clock,
   input  logic              reset,
   input  pft_pkg::req_type  req_data,
   input  logic              csr_valid,
   input  logic [63:0]       csr_data,
   input  pft_pkg::cmd_type  cmd,
   output pft_pkg::stat_type stat,
   output logic              rsp_valid,
   output pft_pkg::rsp_type  rsp_data
);
   import pft_pkg::*;

   entry_type mem [CAPACITY];
   entry_type rdata_ff;

   logic [63:0]      mask_ff;
   req_type          item_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0] removed_ff, removed_in;
   logic             pend_ff, pend_in;
   logic             beaten_ff, beaten_in;
   logic             accepted_ff, accepted_in;
   logic             full_ff, full_in;
   logic             hit_ff, hit_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff;

   logic             cov_a, cov_b, skip;
   logic             scan_issue, beats, dominated;
   logic             mem_we, mem_re;
   logic [IDX_W-1:0] mem_waddr, mem_raddr;
   entry_type        mem_wdata, new_entry;

   assign cov_a = (32'(item_ff.monitor_a) < MONITORS) && mask_ff[item_ff.monitor_a];
   assign cov_b = (32'(item_ff.monitor_b) < MONITORS) && mask_ff[item_ff.monitor_b];
   assign skip  = cov_a && cov_b;

   assign stat.mode      = item_ff.mode;
   assign stat.skip      = skip;
   assign stat.scan_done = (rd_ptr_ff == count_ff) && !pend_ff;

   assign new_entry.id    = item_ff.pair_id;
   assign new_entry.cost  = item_ff.cost;
   assign new_entry.reach = item_ff.reach;

   assign scan_issue = cmd.scan && (rd_ptr_ff != count_ff);
   assign beats      = (rdata_ff.cost < item_ff.cost) && (rdata_ff.reach > item_ff.reach);
   assign dominated  = (item_ff.cost < rdata_ff.cost) && (item_ff.reach > rdata_ff.reach);

   always_comb begin
      count_in    = count_ff;
      rd_ptr_in   = rd_ptr_ff;
      wr_ptr_in   = wr_ptr_ff;
      removed_in  = removed_ff;
      pend_in     = scan_issue;
      beaten_in   = beaten_ff;
      accepted_in = accepted_ff;
      full_in     = full_ff;
      hit_in      = hit_ff;
      mem_we      = 1'b0;
      mem_waddr   = wr_ptr_ff[IDX_W-1:0];
      mem_wdata   = rdata_ff;
      mem_re      = scan_issue || cmd.read;
      mem_raddr   = cmd.read ? IDX_W'(item_ff.read_index) : rd_ptr_ff[IDX_W-1:0];

      if (cmd.load) begin
         rd_ptr_in   = '0;
         wr_ptr_in   = '0;
         removed_in  = '0;
         beaten_in   = 1'b0;
         accepted_in = 1'b0;
         full_in     = 1'b0;
         hit_in      = 1'b0;
      end
      if (cmd.clear) count_in = '0;
      if (cmd.read)  hit_in = (32'(item_ff.read_index) < 32'(count_ff));
      if (scan_issue) rd_ptr_in = CNT_W'(rd_ptr_ff + 1'b1);

      // one entry read last cycle: drop it if the new pair dominates it,
      // otherwise slide it down to the write pointer
      if (pend_ff) begin
         beaten_in = beaten_ff || beats;
         if (dominated) begin
            removed_in = CNT_W'(removed_ff + 1'b1);
         end else begin
            mem_we    = 1'b1;
            wr_ptr_in = CNT_W'(wr_ptr_ff + 1'b1);
         end
      end

      if (cmd.append) begin
         if (beaten_ff) begin
            removed_in = '0;
         end else if (32'(wr_ptr_ff) >= CAPACITY) begin
            full_in  = 1'b1;
            count_in = wr_ptr_ff;
         end else begin
            mem_we      = 1'b1;
            mem_wdata   = new_entry;
            accepted_in = 1'b1;
            count_in    = CNT_W'(wr_ptr_ff + 1'b1);
         end
      end
   end

   always_comb begin
      rsp_in               = '0;
      rsp_in.accepted      = accepted_ff;
      rsp_in.skipped       = (item_ff.mode == MODE_OFFER) && skip;
      rsp_in.full_res      = full_ff;
      rsp_in.removed_count = FIELD_CNT_W'(removed_ff);
      rsp_in.entry_count   = FIELD_CNT_W'(count_ff);
      if ((item_ff.mode == MODE_READ) && hit_ff) begin
         rsp_in.entry_id    = rdata_ff.id;
         rsp_in.entry_cost  = rdata_ff.cost;
         rsp_in.entry_reach = rdata_ff.reach;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (mem_re) rdata_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.load)    item_ff <= req_data;
      if (cmd.respond) rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         count_ff     <= '0;
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         removed_ff   <= '0;
         pend_ff      <= 1'b0;
         beaten_ff    <= 1'b0;
         accepted_ff  <= 1'b0;
         full_ff      <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) mask_ff <= csr_data;
         count_ff     <= count_in;
         rd_ptr_ff    <= rd_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
         removed_ff   <= removed_in;
         pend_ff      <= pend_in;
         beaten_ff    <= beaten_in;
         accepted_ff  <= accepted_in;
         full_ff      <= full_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= cmd.respond;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= CAPACITY)
      else $error("entry count above capacity");

   a_compact_order: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (wr_ptr_ff < rd_ptr_ff))
      else $error("compaction write pointer passed read pointer");

   a_acc_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.accepted && rsp_ff.full_res))
      else $error("item both accepted and rejected as full");

   a_skip_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.skipped) |-> (!rsp_ff.accepted && rsp_ff.removed_count == '0))
      else $error("skipped item changed the front");

endmodule

@@ rtl/pareto_front_table_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pareto_front_table_top
// Pareto front table: keeps pairs that minimize cost and maximize reach.
// ----------------------------------------------------------------------------
// Offer of a pair: the stored entries are scanned against it by the
//   one-entry-per-cycle read/compact pass (one read and at most one write per
//   cycle), then the pair is appended and the result is sent on rsp_valid.
// Clear, read, skipped offer and unused mode go from dispatch to the result.
// One item at a time; busy drops with the result strobe. Results cannot be
//   stalled. Synchronous reset empties the front and clears the monitor
//   mask (mask_ff).
module pareto_front_table_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  pft_pkg::req_type req_data,
   output logic             rsp_valid,
   output pft_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [63:0]      csr_data
);
   import pft_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   pft_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   pft_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
